[rtl/gtst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the generation-tagged slot table.
// Used by every module under rtl; depends on nothing.
package gtst_pkg;

    localparam int SLOTS_DEF = 64;
    localparam logic [6:0] SLOT_COUNT_RST = 7'd64;

    localparam logic [1:0] OP_RESERVE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_INSTALL = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_FATAL   = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic do_reserve;
        logic do_free;
        logic do_install;
    } flag_cmd_t;

endpackage

[rtl/generation_tagged_slot_table_core.sv]
`timescale 1ns / 1ps
// Top level of the generation-tagged slot table: request sequencing, counters,
// result register. Depends on gtst_pkg, gtst_gen_mem and gtst_slot_flags.
//
// Usage:
//   Requests enter on in_valid/in_ready with opcode, slot_index, generation,
//   custody_valid and failure_code. One result per request leaves on
//   out_valid/out_ready, carrying status, grant and the status counters.
//   The slot_count register is written on cfg_valid/cfg_ready (always ready); the user
//   must write it only while no request is in flight, as the block does not enforce this.
//   Each request passes through S_IDLE, where acceptance registers it, reads
//   the tag memory and registers the free-slot search, and S_EXEC, which
//   compares, writes back and loads the result register. No new request is
//   taken until the previous one leaves S_EXEC.
//   A result waiting in the output register does not block the next request;
//   only when that result is still held as the following request reaches
//   S_EXEC does the block wait for out_ready.
//   Reset: all slots free, counters and latches zero, slot_count 64, no
//   clearing pass. Tags are written at reserve before any result depends on them.
module generation_tagged_slot_table_core
    import gtst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [5:0]  slot_index,
    input  logic [63:0] generation,
    input  logic        custody_valid,
    input  logic [9:0]  failure_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [5:0]  granted_index,
    output logic [63:0] granted_generation,
    output logic        terminal,
    output logic [6:0]  occupancy,
    output logic [6:0]  reservations,
    output logic [9:0]  first_fail_code
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UW = ($clog2(SLOTS + 1) > 7) ? $clog2(SLOTS + 1) : 7;

    state_t state_reg, state_next;

    logic [6:0]  slot_count_reg;
    logic [63:0] next_gen_reg, next_gen_next;
    logic [6:0]  res_cnt_reg, res_cnt_next;
    logic [6:0]  ins_cnt_reg, ins_cnt_next;
    logic [9:0]  ff_reg, ff_next;
    logic        term_reg, term_next;
    logic        halted_reg, halted_next;

    logic [1:0]  op_reg;
    logic [5:0]  idx_reg;
    logic [63:0] gen_reg;
    logic        custody_reg;
    logic [9:0]  fail_reg;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [5:0]  gidx_reg, gidx_next;
    logic [63:0] ggen_reg, ggen_next;

    logic          accept, exec_fire;
    logic [UW-1:0] used, in_idx_ext, req_idx_ext, found_ext;
    logic [SW-1:0] rd_addr, req_idx, found_idx;
    logic [63:0]   rd_gen, gen_inc, gen_cand;
    logic          found, res_at, in_range, gen_match;
    logic          mem_we;
    flag_cmd_t     cmd;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign used = (UW'(slot_count_reg) > UW'(SLOTS)) ? UW'(SLOTS) : UW'(slot_count_reg);

    assign in_idx_ext  = UW'(slot_index);
    assign rd_addr     = in_idx_ext[SW-1:0];
    assign req_idx_ext = UW'(idx_reg);
    assign req_idx     = req_idx_ext[SW-1:0];
    assign found_ext   = UW'(found_idx);

    assign in_range  = req_idx_ext < used;
    assign gen_match = rd_gen == gen_reg;
    assign gen_inc   = next_gen_reg + 64'd1;
    assign gen_cand  = (gen_inc == 64'd0) ? 64'd1 : gen_inc;

    gtst_gen_mem #(
        .SLOTS (SLOTS),
        .SW    (SW)
    ) u_gen_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_gen),
        .wr_en   (mem_we),
        .wr_addr (found_idx),
        .wr_data (gen_cand)
    );

    gtst_slot_flags #(
        .SLOTS (SLOTS),
        .SW    (SW),
        .UW    (UW)
    ) u_slot_flags (
        .clk       (clk),
        .rst_n     (rst_n),
        .search_en (accept),
        .used      (used),
        .cmd       (cmd),
        .req_idx   (req_idx),
        .found     (found),
        .found_idx (found_idx),
        .res_at    (res_at)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_EXEC:  in_ready = 1'b0;
            default: in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        mem_we        = 1'b0;
        next_gen_next = next_gen_reg;
        res_cnt_next  = res_cnt_reg;
        ins_cnt_next  = ins_cnt_reg;
        ff_next       = ff_reg;
        term_next     = term_reg;
        halted_next   = halted_reg;
        status_next   = ST_REFUSED;
        gidx_next     = '0;
        ggen_next     = '0;
        if (halted_reg)
        begin
            status_next = ST_FATAL;
        end
        else
        begin
            case (op_reg)
                OP_RESERVE:
                begin
                    if (!term_reg && found)
                    begin
                        status_next    = ST_OK;
                        gidx_next      = found_ext[5:0];
                        ggen_next      = gen_cand;
                        cmd.do_reserve = exec_fire;
                        mem_we         = exec_fire;
                        next_gen_next  = gen_cand;
                        res_cnt_next   = res_cnt_reg + 7'd1;
                    end
                end
                OP_RELEASE:
                begin
                    if (in_range && res_at && gen_match)
                    begin
                        status_next  = ST_OK;
                        cmd.do_free  = exec_fire;
                        res_cnt_next = res_cnt_reg - 7'd1;
                    end
                end
                OP_INSTALL:
                begin
                    if (!in_range || !custody_reg || !res_at || !gen_match)
                    begin
                        status_next = ST_FATAL;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        status_next    = ST_OK;
                        cmd.do_install = exec_fire;
                        res_cnt_next   = res_cnt_reg - 7'd1;
                        ins_cnt_next   = ins_cnt_reg + 7'd1;
                        term_next      = 1'b1;
                        if (ff_reg == 10'd0)
                        begin
                            ff_next = fail_reg;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_REFUSED;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_count_reg <= SLOT_COUNT_RST;
            next_gen_reg   <= '0;
            res_cnt_reg    <= '0;
            ins_cnt_reg    <= '0;
            ff_reg         <= '0;
            term_reg       <= 1'b0;
            halted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                slot_count_reg <= cfg_data;
            end
            if (exec_fire)
            begin
                next_gen_reg <= next_gen_next;
                res_cnt_reg  <= res_cnt_next;
                ins_cnt_reg  <= ins_cnt_next;
                ff_reg       <= ff_next;
                term_reg     <= term_next;
                halted_reg   <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            idx_reg     <= slot_index;
            gen_reg     <= generation;
            custody_reg <= custody_valid;
            fail_reg    <= failure_code;
        end
        if (exec_fire)
        begin
            status_reg         <= status_next;
            gidx_reg           <= gidx_next;
            ggen_reg           <= ggen_next;
            terminal           <= term_next;
            occupancy          <= ins_cnt_next;
            reservations       <= res_cnt_next;
            first_fail_code    <= ff_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign granted_index      = gidx_reg;
    assign granted_generation = ggen_reg;

    a_halt_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt latch cleared");

    a_term_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        term_reg |=> term_reg)
        else $error("terminal latch cleared");

    a_grant_ok_only : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (granted_index == 6'd0)
            && (granted_generation == 64'd0))
        else $error("grant fields set on a failed request");

    a_exec_one_result : assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid && (state_reg == S_IDLE))
        else $error("result not loaded after execute");

endmodule

[rtl/gtst_gen_mem.sv]
`timescale 1ns / 1ps
// Generation tag store: one synchronous write port, one registered read port.
// Depends on gtst_pkg for the default depth.
module gtst_gen_mem
    import gtst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [SW-1:0] rd_addr,
    output logic [63:0]   rd_data,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  logic [63:0]   wr_data
);

    logic [63:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/gtst_slot_flags.sv]
`timescale 1ns / 1ps
// Per-slot reserved and installed flags with the lowest-free-slot search.
// Depends on gtst_pkg for flag_cmd_t and the default depth.
module gtst_slot_flags
    import gtst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int UW    = ($clog2(SLOTS + 1) > 7) ? $clog2(SLOTS + 1) : 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          search_en,
    input  logic [UW-1:0] used,
    input  flag_cmd_t     cmd,
    input  logic [SW-1:0] req_idx,
    output logic          found,
    output logic [SW-1:0] found_idx,
    output logic          res_at
);

    logic [SLOTS-1:0] res_reg, res_next;
    logic [SLOTS-1:0] ins_reg, ins_next;
    logic [SLOTS-1:0] free_vec, low_vec;
    logic [SW-1:0]    enc;
    logic             found_reg;
    logic [SW-1:0]    found_idx_reg;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            free_vec[i] = !res_reg[i] && !ins_reg[i] && (UW'(i) < used);
        end
        low_vec = free_vec & (~free_vec + SLOTS'(1));
        enc = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (low_vec[i])
            begin
                enc = enc | SW'(i);
            end
        end
    end

    always_comb
    begin
        res_next = res_reg;
        ins_next = ins_reg;
        if (cmd.do_reserve)
        begin
            res_next[found_idx_reg] = 1'b1;
        end
        if (cmd.do_free)
        begin
            res_next[req_idx] = 1'b0;
        end
        if (cmd.do_install)
        begin
            res_next[req_idx] = 1'b0;
            ins_next[req_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg   <= '0;
            ins_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            res_reg <= res_next;
            ins_reg <= ins_next;
            if (search_en)
            begin
                found_reg <= |free_vec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (search_en)
        begin
            found_idx_reg <= enc;
        end
    end

    assign found     = found_reg;
    assign found_idx = found_idx_reg;
    assign res_at    = res_reg[req_idx];

endmodule
